// File: design/ifdl_pkg.sv
// Shared constants, register indexes and saturation helper for the delay line.
`default_nettype none

package ifdl_pkg;

	// Default ring depth in samples.
	localparam int IFDL_MAX_DELAY = 65536;

	// Fixed field widths.
	localparam int SMP_W  = 24;
	localparam int FRAC_W = 16;
	localparam int GAIN_W = 16;
	localparam int LEN_W  = 17;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERP_FRACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN   = 2'd2;

	// Register reset values.
	localparam int LEN_RESET = 100;

	localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;

	// Clamp a sum of two samples to the Q1.23 range.
	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SMP_W+1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > (SMP_W+2)'(SMP_MAX)) begin
			r = SMP_MAX;
		end else if (v < (SMP_W+2)'(SMP_MIN)) begin
			r = SMP_MIN;
		end else begin
			r = v[SMP_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/ifdl_ring.sv
// Sample ring memory: one write port and one registered read port.
`default_nettype none

module ifdl_ring
	import ifdl_pkg::*;
#(
	parameter int DEPTH = IFDL_MAX_DELAY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic signed [SMP_W-1:0] rdata
);

	logic signed [SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read and a write of the same entry in one cycle return the old data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: design/ifdl_mod.sv
// Bit-serial restoring remainder unit for wrapping the ring position.
`default_nettype none

module ifdl_mod
	import ifdl_pkg::*;
#(
	parameter int AW = $clog2(IFDL_MAX_DELAY),
	parameter int NW = LEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [AW:0]   dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [AW-1:0] rem
);

	localparam int STEPS = AW + 1;
	localparam int CW    = $clog2(STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [AW:0]   dvd_q;
	logic [NW-1:0] rem_q;

	logic [NW:0] trial;
	logic [NW:0] trial_sub;
	logic        fits;

	// Bring down one dividend bit per cycle; the remainder stays below the divisor.
	assign trial     = {rem_q, dvd_q[AW]};
	assign fits      = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[AW-1:0], 1'b0};
			rem_q <= fits ? trial_sub[NW-1:0] : trial[NW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[AW-1:0];

endmodule

`default_nettype wire

// File: design/interpolated_feedback_delay_line_top.sv
// Fractional-delay feedback comb: sequencer, arithmetic and configuration registers.
// Sequence: an accepted item passes the two ring reads, two multiply stages and the write-back;
// the write-back waits while out_stall holds the previous result. A position beyond a shortened
// ring first passes the remainder unit. A new item is taken only after the last is written back.
// Reset: a clearing pass writes zero to all MAX_DELAY ring entries with in_stall high;
// configuration writes are taken during the pass.
`default_nettype none

module interpolated_feedback_delay_line_top
	import ifdl_pkg::*;
#(
	parameter int MAX_DELAY = IFDL_MAX_DELAY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [SMP_W-1:0]  sample_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SMP_W-1:0]  sample_out,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(MAX_DELAY);
	localparam int NW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
	localparam logic [NW-1:0] N_MAX = NW'(MAX_DELAY);
	localparam logic [NW-1:0] N_RST = (LEN_RESET > MAX_DELAY) ? NW'(MAX_DELAY) : NW'(LEN_RESET);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_MOD,
		S_RDW,
		S_RDN,
		S_MAC,
		S_FB,
		S_WR
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             clr_q;
	logic [AW-1:0]             wp_q;
	logic [AW-1:0]             w_q;
	logic [NW-1:0]             n_q;
	logic [FRAC_W-1:0]         frac_q;
	logic signed [GAIN_W-1:0]  gain_q;
	logic                      out_valid_q;

	logic signed [SMP_W-1:0]   x_q;
	logic signed [SMP_W-1:0]   old_q;
	logic signed [SMP_W-1:0]   y_q;
	logic signed [SMP_W+GAIN_W-1:0] prod_q;
	logic signed [SMP_W-1:0]   out_q;

	logic                      in_take;
	logic                      out_free;
	logic                      wr_go;
	logic [NW-1:0]             wp1;
	logic                      need_mod;
	logic [AW-1:0]             w_direct;
	logic [NW-1:0]             nx_full;
	logic [AW-1:0]             nx;
	logic [NW-1:0]             cfg_len;
	logic [NW-1:0]             n_new;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [SMP_W-1:0]   mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic signed [SMP_W-1:0]   mem_rdata;

	logic                      mod_done;
	logic [AW-1:0]             mod_rem;

	logic signed [SMP_W:0]     diff;
	logic signed [SMP_W+FRAC_W+1:0] mac;
	logic signed [SMP_W+FRAC_W+1:0] acc;
	logic signed [SMP_W+GAIN_W-1:0] fb_prod;
	logic signed [SMP_W+GAIN_W-1:0] fb_rnd;
	logic signed [SMP_W:0]     fb;
	logic signed [SMP_W+1:0]   sum;
	logic signed [SMP_W-1:0]   s_sat;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign wr_go     = (state_q == S_WR) && out_free;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	// Next oldest slot: a plain wrap unless the position lies past a shortened ring.
	assign wp1      = NW'(wp_q) + NW'(1);
	assign need_mod = wp1 > n_q;
	assign w_direct = (wp1 == n_q) ? '0 : wp1[AW-1:0];

	assign nx_full = NW'(w_q) + NW'(1);
	assign nx      = (nx_full == n_q) ? '0 : nx_full[AW-1:0];

	// Ring length clamped to 1..MAX_DELAY when written.
	assign cfg_len = NW'(cfg_data);
	always_comb begin
		priority if (cfg_len == '0) begin
			n_new = NW'(1);
		end else if (cfg_len > N_MAX) begin
			n_new = N_MAX;
		end else begin
			n_new = cfg_len;
		end
	end

	assign mem_raddr = (state_q == S_RDN) ? nx : w_q;
	assign mem_we    = (state_q == S_CLR) || wr_go;
	assign mem_waddr = (state_q == S_CLR) ? clr_q : w_q;
	assign mem_wdata = (state_q == S_CLR) ? '0 : s_sat;

	// Interpolation as newer + frac * (oldest - newer), exact, then rounded by 2^16.
	assign diff = (SMP_W+1)'(old_q) - (SMP_W+1)'(mem_rdata);
	assign mac  = $signed({1'b0, frac_q}) * diff;
	assign acc  = mac + ((SMP_W+FRAC_W+2)'(mem_rdata) <<< FRAC_W)
		+ (SMP_W+FRAC_W+2)'(32768);

	// Feedback product rounded by 2^15, added to the input and saturated.
	assign fb_prod = gain_q * y_q;
	assign fb_rnd  = prod_q + (SMP_W+GAIN_W)'(16384);
	assign fb      = fb_rnd[SMP_W+GAIN_W-1:GAIN_W-1];
	assign sum     = (SMP_W+2)'(x_q) + (SMP_W+2)'(fb);
	assign s_sat   = sat_smp(sum);

	ifdl_ring #(
		.DEPTH(MAX_DELAY),
		.AW   (AW)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ifdl_mod #(
		.AW(AW),
		.NW(NW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_take && need_mod),
		.dividend(wp1[AW:0]),
		.divisor (n_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			wp_q        <= '0;
			w_q         <= '0;
			n_q         <= N_RST;
			frac_q      <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_DELAY_LENGTH:    n_q    <= n_new;
					REG_INTERP_FRACTION: frac_q <= cfg_data[FRAC_W-1:0];
					REG_FEEDBACK_GAIN:   gain_q <= $signed(cfg_data[GAIN_W-1:0]);
					default: ;
				endcase
			end

			priority if (wr_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (wr_go) begin
				out_q <= y_q;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_DELAY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_take) begin
						if (need_mod) begin
							state_q <= S_MOD;
						end else begin
							w_q     <= w_direct;
							state_q <= S_RDW;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						w_q     <= mod_rem;
						state_q <= S_RDW;
					end
				end
				S_RDW: state_q <= S_RDN;
				S_RDN: state_q <= S_MAC;
				S_MAC: state_q <= S_FB;
				S_FB:  state_q <= S_WR;
				S_WR: begin
					// Hold the write-back until the previous result has been taken.
					if (out_free) begin
						wp_q    <= w_q;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q <= sample_in;
		end
		if (state_q == S_RDN) begin
			old_q <= mem_rdata;
		end
		if (state_q == S_MAC) begin
			y_q <= acc[SMP_W+FRAC_W-1:FRAC_W];
		end
		if (state_q == S_FB) begin
			prod_q <= fb_prod;
		end
	end

endmodule

`default_nettype wire
